>>> rtl/core/kbmc_pkg.sv
// kbmc_pkg: shared types and codes of the keyed block mixer with counter
`default_nettype none

package kbmc_pkg;

    // block size modes carried on the input tuser
    localparam logic [1:0] MODE_8B  = 2'd0;
    localparam logic [1:0] MODE_16B = 2'd1;
    localparam logic [1:0] MODE_32B = 2'd2;
    localparam logic [1:0] MODE_64B = 2'd3;

    localparam int NUM_WORDS = 8;
    localparam int LEN_W     = 10;

    // one queued block with its requested length
    typedef struct packed {
        logic [1:0]                  mode;
        logic [NUM_WORDS-1:0][63:0]  words;
        logic [LEN_W-1:0]            len;
    } item_t;

endpackage

`default_nettype wire

>>> rtl/core/keyed_block_mixer_counter_unit.sv
// keyed_block_mixer_counter_unit: top level of the keyed block mixer with running counter
//
//  channel  | dir | handshake                    | contents
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | one block, its mode and output length
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | one output word per beat, tlast on final
//
// each finalizer mix runs in the shared mix unit; block setup costs 1, 1, 8 or 12 mixes
// for the 8, 16, 32, 64 byte modes, then the output words are emitted, plus one mix per
// chained word (two in the 16 byte mode)
// reset clears the counter, the queue and the sequencer
// a two-entry queue takes new blocks while the sequencer works or the output stalls
`default_nettype none

module keyed_block_mixer_counter_unit #(
    parameter int MAX_OUT_BYTES = 512
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [527:0]   s_axis_tdata,   // word0..word7, out_bytes, zero pad
    input  wire logic [1:0]     s_axis_tuser,   // operation
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [71:0]         m_axis_tdata,   // out_word, valid_bytes, zero pad
    output logic                m_axis_tlast    // last
);

    logic               q_valid, q_ready;
    kbmc_pkg::item_t    q_item;

    kbmc_front #(
        .MAX_OUT_BYTES (MAX_OUT_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    kbmc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/core/kbmc_front.sv
// kbmc_front: input beat acceptance, length clamp and two-entry item queue
`default_nettype none

module kbmc_front #(
    parameter int MAX_OUT_BYTES = 512
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [527:0]       s_axis_tdata,   // word0..word7, out_bytes, zero pad
    input  wire logic [1:0]         s_axis_tuser,   // operation
    output logic                    q_valid,
    input  wire logic               q_ready,
    output kbmc_pkg::item_t         q_item
);

    localparam int SatInt = (MAX_OUT_BYTES > 1023) ? 1023 : MAX_OUT_BYTES;
    localparam logic [kbmc_pkg::LEN_W-1:0] SatLen = kbmc_pkg::LEN_W'(SatInt);

    kbmc_pkg::item_t    mem_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic [kbmc_pkg::LEN_W-1:0] len_raw, len_sat;
    logic               push, pop;
    kbmc_pkg::item_t    in_item;

    // clamp length and build the queue entry
    always_comb
    begin
        len_raw = s_axis_tdata[521:512];
        len_sat = (len_raw > SatLen) ? SatLen : len_raw;
        in_item.mode  = s_axis_tuser;
        in_item.words = s_axis_tdata[511:0];
        in_item.len   = len_sat;
    end

    assign s_axis_tready = (count_reg != 2'd2);
    // a zero length beat is taken and dropped
    assign push    = s_axis_tvalid && s_axis_tready && (len_sat != '0);
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_ready && q_valid;
    assign q_item  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/kbmc_fmix.sv
// kbmc_fmix: 64-bit finalizer mix built from 32x32 partial products, run through sum, multiply and sum phases
`default_nettype none

module kbmc_fmix (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] x,
    output logic             busy,
    output logic             done,
    output logic [63:0]      result
);

    localparam logic [63:0] C1 = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] C2 = 64'hC4CEB9FE1A85EC53;

    typedef enum logic [1:0] {PH_IDLE, PH_SUM1, PH_MUL2, PH_SUM2} phase_t;

    phase_t         phase_reg;
    logic           done_reg;
    logic [63:0]    p0_reg;
    logic [31:0]    p1_reg, p2_reg;
    logic [63:0]    y_reg, res_reg;
    logic [63:0]    a, mul_c, sum, shx;
    logic [63:0]    p0_next;
    logic [31:0]    p1_next, p2_next;

    // partial products of the low 64 bits of a times the round constant
    always_comb
    begin
        if (phase_reg == PH_MUL2)
        begin
            a     = y_reg ^ (y_reg >> 33);
            mul_c = C2;
        end
        else
        begin
            a     = x ^ (x >> 33);
            mul_c = C1;
        end
        p0_next = a[31:0] * mul_c[31:0];
        p1_next = 32'(a[63:32] * mul_c[31:0]);
        p2_next = 32'(a[31:0] * mul_c[63:32]);
        sum     = p0_reg + {p1_reg + p2_reg, 32'd0};
        shx     = sum ^ (sum >> 33);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (phase_reg == PH_SUM2);
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= PH_SUM1;
                    end
                end
                PH_SUM1:
                begin
                    phase_reg <= PH_MUL2;
                end
                PH_MUL2:
                begin
                    phase_reg <= PH_SUM2;
                end
                PH_SUM2:
                begin
                    phase_reg <= PH_IDLE;
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if ((phase_reg == PH_IDLE && start) || phase_reg == PH_MUL2)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (phase_reg == PH_SUM1)
        begin
            y_reg <= sum;
        end
        if (phase_reg == PH_SUM2)
        begin
            res_reg <= shx;
        end
    end

    assign busy   = (phase_reg != PH_IDLE) || done_reg;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

>>> rtl/core/kbmc_back.sv
// kbmc_back: round sequencer, counter update and output word emission
`default_nettype none

module kbmc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire kbmc_pkg::item_t    q_item,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [71:0]             m_axis_tdata,   // out_word, valid_bytes, zero pad
    output logic                    m_axis_tlast    // last
);

    typedef enum logic [2:0] {S_IDLE, S_START, S_WAIT, S_CROSS, S_CTR, S_EMIT} state_t;

    localparam logic [63:0] K0 = 64'h428A2F98D728AE22;
    localparam logic [63:0] K1 = 64'h7137449123EF65CD;
    localparam logic [63:0] K2 = 64'hB5C0FBCFEC4D3B2F;
    localparam logic [63:0] K3 = 64'hE9B5DBA58189DBBC;
    localparam logic [63:0] K4 = 64'h3956C25BF348B538;
    localparam logic [63:0] K5 = 64'h59F111F1B605D019;
    localparam logic [63:0] K6 = 64'h923F82A4AF194F9B;
    localparam logic [63:0] K7 = 64'hAB1C5ED5DA6D8118;

    function automatic logic [63:0] key_word(input logic [2:0] i);
        logic [63:0] k;
        unique case (i)
            3'd0: k = K0;
            3'd1: k = K1;
            3'd2: k = K2;
            3'd3: k = K3;
            3'd4: k = K4;
            3'd5: k = K5;
            3'd6: k = K6;
            default: k = K7;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] ror64(input logic [63:0] v, input logic [5:0] n);
        logic [127:0] d;
        d = {v, v} >> n;
        return d[63:0];
    endfunction

    function automatic logic [63:0] rol64(input logic [63:0] v, input logic [5:0] n);
        logic [127:0] d;
        d = {v, v} << n;
        return d[127:64];
    endfunction

    state_t         state_reg;
    logic [1:0]     mode_reg;
    logic [63:0]    v_reg [8];
    logic [63:0]    cnt_reg;
    logic [9:0]     rem_reg;
    logic [2:0]     idx_reg;
    logic           wrap_reg;
    logic [3:0]     opcnt_reg;
    logic           regen_reg;
    logic           second_reg;
    logic           out_valid_reg;
    logic [63:0]    out_word_reg;
    logic [3:0]     out_vb_reg;
    logic           out_last_reg;

    logic           fx_start, fx_busy, fx_done;
    logic [63:0]    fx_x, fx_res, partner;
    logic [63:0]    v_wb [8];
    logic [63:0]    v_rot [8];
    logic [63:0]    v_cross [8];
    logic [63:0]    v_ctr [8];
    logic [3:0]     nw;
    logic [1:0]     j;
    logic [5:0]     ra, rb, rc;
    logic [3:0]     nidx;
    logic           regen_need, out_free, out_load, is_last;
    logic [3:0]     vb;
    logic [63:0]    emit_word, mask;

    kbmc_fmix u_fmix (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fx_start),
        .x      (fx_x),
        .busy   (fx_busy),
        .done   (fx_done),
        .result (fx_res)
    );

    assign nw       = 4'd1 << mode_reg;
    assign j        = opcnt_reg[1:0];
    assign fx_start = (state_reg == S_START);
    assign q_ready  = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = (state_reg == S_EMIT) && out_free;

    // operand of the mix: slot 0 against the partner slot or a key word
    always_comb
    begin
        unique case (mode_reg)
            kbmc_pkg::MODE_8B:  partner = key_word(idx_reg);
            kbmc_pkg::MODE_16B: partner = v_reg[1];
            kbmc_pkg::MODE_32B: partner = regen_reg ? v_reg[2] : v_reg[1];
            default:            partner = regen_reg ? v_reg[4] : v_reg[1];
        endcase
        fx_x = v_reg[0] ^ partner;
    end

    // rotation amounts of the cross-mix rounds
    always_comb
    begin
        unique case (j)
            2'd0: begin ra = 6'd13; rb = 6'd11; rc = 6'd19; end
            2'd1: begin ra = 6'd20; rb = 6'd13; rc = 6'd21; end
            2'd2: begin ra = 6'd27; rb = 6'd15; rc = 6'd23; end
            default: begin ra = 6'd34; rb = 6'd17; rc = 6'd25; end
        endcase
    end

    // write back of a mix result, the slot ring turning where the mode asks
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            v_wb[i] = v_reg[i];
        end
        priority if (mode_reg == kbmc_pkg::MODE_8B)
        begin
            v_wb[0] = regen_reg ? fx_res : ror64(fx_res ^ K1, 6'd23);
        end
        else if (mode_reg == kbmc_pkg::MODE_16B)
        begin
            if (regen_reg)
            begin
                v_wb[0] = v_reg[1];
                v_wb[1] = fx_res;
            end
            else
            begin
                v_wb[0] = ror64(fx_res, 6'd17) ^ K2;
                v_wb[1] = rol64(fx_res, 6'd31) ^ K3;
            end
        end
        else if (mode_reg == kbmc_pkg::MODE_32B)
        begin
            v_wb[0] = v_reg[1];
            v_wb[1] = v_reg[2];
            v_wb[2] = v_reg[3];
            v_wb[3] = regen_reg ? fx_res : ror64(fx_res, ra);
        end
        else if (regen_reg)
        begin
            for (int i = 0; i < 7; i++)
            begin
                v_wb[i] = v_reg[i+1];
            end
            v_wb[7] = fx_res;
        end
        else
        begin
            for (int i = 0; i < 6; i++)
            begin
                v_wb[i] = v_reg[i+2];
            end
            v_wb[6] = ror64(fx_res, rb);
            v_wb[7] = rol64(fx_res, rc);
        end
    end

    // ring turn after an emitted word, cross step and counter xor
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            v_rot[i] = v_reg[i];
            v_ctr[i] = (4'(i) < nw) ? (v_reg[i] ^ (cnt_reg + 64'(i))) : v_reg[i];
        end
        if (mode_reg == kbmc_pkg::MODE_32B)
        begin
            v_rot[0] = v_reg[1];
            v_rot[1] = v_reg[2];
            v_rot[2] = v_reg[3];
            v_rot[3] = v_reg[0];
        end
        else if (mode_reg == kbmc_pkg::MODE_64B)
        begin
            for (int i = 0; i < 7; i++)
            begin
                v_rot[i] = v_reg[i+1];
            end
            v_rot[7] = v_reg[0];
        end
        for (int i = 0; i < 4; i++)
        begin
            v_cross[i]   = v_reg[i] ^ v_reg[i+4];
            v_cross[i+4] = v_reg[i];
        end
    end

    // output word, byte count and chaining decision
    always_comb
    begin
        is_last   = (rem_reg <= 10'd8);
        vb        = is_last ? rem_reg[3:0] : 4'd8;
        mask      = (vb == 4'd8) ? '1 : ((64'd1 << {vb[2:0], 3'b000}) - 64'd1);
        emit_word = ((mode_reg == kbmc_pkg::MODE_16B) && idx_reg[0]) ? v_reg[1] : v_reg[0];
        emit_word = emit_word & mask;
        nidx      = {1'b0, idx_reg} + 4'd1;
        regen_need = (mode_reg == kbmc_pkg::MODE_8B) || wrap_reg || (nidx >= nw);
    end

    // sequencer, work slots and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= kbmc_pkg::MODE_8B;
            rem_reg       <= '0;
            idx_reg       <= '0;
            wrap_reg      <= 1'b0;
            opcnt_reg     <= '0;
            regen_reg     <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        mode_reg  <= q_item.mode;
                        rem_reg   <= q_item.len;
                        idx_reg   <= '0;
                        wrap_reg  <= 1'b0;
                        opcnt_reg <= '0;
                        regen_reg <= 1'b0;
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (fx_done)
                    begin
                        if (!regen_reg)
                        begin
                            opcnt_reg <= opcnt_reg + 4'd1;
                            unique case (mode_reg)
                                kbmc_pkg::MODE_8B, kbmc_pkg::MODE_16B:
                                    state_reg <= S_CTR;
                                kbmc_pkg::MODE_32B:
                                    state_reg <= (opcnt_reg == 4'd7) ? S_CTR : S_START;
                                default:
                                    state_reg <= (j == 2'd3) ? S_CROSS : S_START;
                            endcase
                        end
                        else if ((mode_reg == kbmc_pkg::MODE_16B) && !second_reg)
                        begin
                            second_reg <= 1'b1;
                            state_reg  <= S_START;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_CROSS:
                begin
                    state_reg <= (opcnt_reg == 4'd12) ? S_CTR : S_START;
                end
                S_CTR:
                begin
                    cnt_reg   <= cnt_reg + 64'(nw);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        if (is_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            rem_reg  <= rem_reg - 10'd8;
                            idx_reg  <= nidx[2:0];
                            wrap_reg <= wrap_reg | nidx[3];
                            if (regen_need)
                            begin
                                regen_reg  <= 1'b1;
                                second_reg <= 1'b0;
                                state_reg  <= S_START;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word_reg <= emit_word;
            out_vb_reg   <= vb;
            out_last_reg <= is_last;
        end
        for (int i = 0; i < 8; i++)
        begin
            priority if (state_reg == S_IDLE && q_valid)
            begin
                if (i == 0 && q_item.mode == kbmc_pkg::MODE_8B)
                begin
                    v_reg[i] <= q_item.words[i];
                end
                else
                begin
                    v_reg[i] <= q_item.words[i] ^ key_word(3'(i));
                end
            end
            else if (state_reg == S_WAIT && fx_done)
            begin
                v_reg[i] <= v_wb[i];
            end
            else if (state_reg == S_CROSS)
            begin
                v_reg[i] <= v_cross[i];
            end
            else if (state_reg == S_CTR)
            begin
                v_reg[i] <= v_ctr[i];
            end
            else if (out_load && !is_last && !regen_need)
            begin
                v_reg[i] <= v_rot[i];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_vb_reg, out_word_reg};
    assign m_axis_tlast  = out_last_reg;

    // a mix is only issued to an idle unit
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fx_start |-> !fx_busy)
        else $error("mix started while busy");

    // a new word never overwrites one still waiting downstream
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("output overwritten");

    // the final word of a block returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_last) |=> (state_reg == S_IDLE))
        else $error("sequencer busy after last word");

    // a mix result only arrives while waiting for it
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        fx_done |-> (state_reg == S_WAIT))
        else $error("mix result outside wait");

endmodule

`default_nettype wire
